FILE: src/stm_pkg.sv
// Package for the spherical texture mapping core: beat types, pipeline cell
// payloads, the arctangent table and the vector set-up function. No dependencies.
`timescale 1ns / 1ps

package stm_pkg;

  localparam int AngW = 34;
  localparam logic signed [AngW-1:0] HalfTurn = 34'sd2147483648;
  localparam int Prescale = 14;
  localparam int SqrtSteps = 16;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } stm_in_t;

  typedef struct packed {
    logic [15:0] tex_u;
    logic [16:0] tex_v;
  } stm_out_t;

  // Payload of the square-root cells: the remainder and partial root for the
  // polar side, and the raw normal carried along for the azimuth side.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        rem;
    logic [31:0]        root;
  } stm_root_t;

  typedef struct packed {
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic                   zero;
  } stm_vec_t;

  typedef struct packed {
    stm_vec_t az;
    stm_vec_t pol;
  } stm_pair_t;

  // atan(2^-i) in units of 2^-32 of a full turn.
  function automatic logic signed [AngW-1:0] atan_turns(input int i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = 34'sd536870912;   1: r = 34'sd316933406;
      2: r = 34'sd167458907;   3: r = 34'sd85004756;
      4: r = 34'sd42667331;    5: r = 34'sd21354465;
      6: r = 34'sd10679838;    7: r = 34'sd5340245;
      8: r = 34'sd2670163;     9: r = 34'sd1335087;
      10: r = 34'sd667544;     11: r = 34'sd333772;
      12: r = 34'sd166886;     13: r = 34'sd83443;
      14: r = 34'sd41722;      15: r = 34'sd20861;
      16: r = 34'sd10430;      17: r = 34'sd5215;
      18: r = 34'sd2608;       19: r = 34'sd1304;
      20: r = 34'sd652;        21: r = 34'sd326;
      22: r = 34'sd163;        23: r = 34'sd81;
      24: r = 34'sd41;         25: r = 34'sd20;
      26: r = 34'sd10;         27: r = 34'sd5;
      28: r = 34'sd3;          29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Folds a left-half-plane vector into the right half and applies the
  // prescale ahead of the first micro-rotation. The inputs are one bit wider
  // than a normal component so that a square root of exactly one fits.
  function automatic stm_vec_t prep_vec(input logic signed [16:0] x,
                                        input logic signed [16:0] y);
    stm_vec_t v;
    logic signed [AngW-1:0] xe;
    logic signed [AngW-1:0] ye;
    xe = AngW'(x);
    ye = AngW'(y);
    v.zero = (x == 17'sd0) && (y == 17'sd0);
    if (x < 0) begin
      xe = -xe;
      ye = -ye;
      v.ang = HalfTurn;
    end else begin
      v.ang = '0;
    end
    v.x = xe <<< Prescale;
    v.y = ye <<< Prescale;
    return v;
  endfunction

endpackage

FILE: src/spherical_texture_mapping_core.sv
// Top level of the spherical texture mapping core: input register, square-root
// chain, CORDIC chain and output register. Depends on stm_pkg and both cell modules.
`timescale 1ns / 1ps

// Takes one normal beat per cycle while not stalled and returns one texture
// coordinate beat per normal, in order. The pipeline is one input stage that
// also forms 1 - z*z, sixteen square-root cells, one CORDIC cell per iteration
// and the output stage. The whole chain advances together, so a stall on the
// output holds every stage; with no stall the rate is one beat per clock.
module spherical_texture_mapping_core
  import stm_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     normal_valid,
  output logic     normal_stall,
  input  stm_in_t  normal,
  output logic     tex_valid,
  input  logic     tex_stall,
  output stm_out_t tex
);

  logic en;
  assign en = !(tex_valid && tex_stall);
  assign normal_stall = !en;

  logic      sq_v [SqrtSteps+1];
  stm_root_t sq_d [SqrtSteps+1];
  logic      cd_v [ANGLE_ITERATIONS+1];
  stm_pair_t cd_d [ANGLE_ITERATIONS+1];

  logic signed [31:0] zsq;
  assign zsq = normal.normal_z * normal.normal_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= normal_valid;
    end
    if (en) begin
      sq_d[0].x    <= normal.normal_x;
      sq_d[0].y    <= normal.normal_y;
      sq_d[0].z    <= normal.normal_z;
      sq_d[0].rem  <= 32'd1073741824 - 32'(zsq);
      sq_d[0].root <= '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    stm_sqrt_cell #(.STEP(k)) u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (sq_v[k]), .din (sq_d[k]),
      .vout(sq_v[k+1]), .dout(sq_d[k+1])
    );
  end

  // The root reaches 2^15 when z is zero, so it enters as a positive 17-bit value.
  assign cd_v[0]     = sq_v[SqrtSteps];
  assign cd_d[0].az  = prep_vec(17'(sq_d[SqrtSteps].x), 17'(sq_d[SqrtSteps].y));
  assign cd_d[0].pol = prep_vec(17'(sq_d[SqrtSteps].z),
                                signed'({1'b0, sq_d[SqrtSteps].root[15:0]}));

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    stm_cordic_cell #(.SHIFT(i)) u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (cd_v[i]), .din (cd_d[i]),
      .vout(cd_v[i+1]), .dout(cd_d[i+1])
    );
  end

  logic signed [AngW-1:0] az;
  logic signed [AngW-1:0] pol;
  logic signed [AngW-1:0] az_rnd;
  logic signed [AngW-1:0] pol_rnd;
  stm_out_t tex_next;

  always_comb begin
    az  = cd_d[ANGLE_ITERATIONS].az.zero ? '0 : cd_d[ANGLE_ITERATIONS].az.ang;
    pol = cd_d[ANGLE_ITERATIONS].pol.zero ? '0 : cd_d[ANGLE_ITERATIONS].pol.ang;
    // CORDIC drift may push the polar angle just outside [0, pi].
    if (pol < 0) begin
      pol = '0;
    end else if (pol > HalfTurn) begin
      pol = HalfTurn;
    end
    az_rnd  = az + AngW'(32768);
    pol_rnd = pol + AngW'(16384);
    tex_next.tex_u = az_rnd[31:16];
    tex_next.tex_v = pol_rnd[31:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_valid <= 1'b0;
    end else if (en) begin
      tex_valid <= cd_v[ANGLE_ITERATIONS];
    end
    if (en) begin
      tex <= tex_next;
    end
  end

endmodule

FILE: src/stm_sqrt_cell.sv
// One digit step of the integer square root, two remainder bits per cell.
// Depends on stm_pkg.
`timescale 1ns / 1ps

module stm_sqrt_cell
  import stm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vin,
  input  stm_root_t din,
  output logic      vout,
  output stm_root_t dout
);

  localparam logic [31:0] Bit = 32'(1) << (2 * (SqrtSteps - 1 - STEP));

  stm_root_t dout_next;
  logic [31:0] trial;

  always_comb begin
    trial = din.root + Bit;
    dout_next = din;
    if (din.rem >= trial) begin
      dout_next.rem  = din.rem - trial;
      dout_next.root = (din.root >> 1) + Bit;
    end else begin
      dout_next.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: src/stm_cordic_cell.sv
// One CORDIC vectoring micro-rotation, applied to the azimuth and the polar
// vectors side by side. Depends on stm_pkg.
`timescale 1ns / 1ps

module stm_cordic_cell
  import stm_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vin,
  input  stm_pair_t din,
  output logic      vout,
  output stm_pair_t dout
);

  localparam logic signed [AngW-1:0] Atan = atan_turns(SHIFT);

  function automatic stm_vec_t rotate(input stm_vec_t a);
    stm_vec_t r;
    logic signed [AngW-1:0] xs;
    logic signed [AngW-1:0] ys;
    xs = a.x >>> SHIFT;
    ys = a.y >>> SHIFT;
    r = a;
    if (a.y > 0) begin
      r.x   = a.x + ys;
      r.y   = a.y - xs;
      r.ang = a.ang + Atan;
    end else begin
      r.x   = a.x - ys;
      r.y   = a.y + xs;
      r.ang = a.ang - Atan;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout.az  <= rotate(din.az);
      dout.pol <= rotate(din.pol);
    end
  end

endmodule

FILE: src/stm_checker.sv
// Port-level checks for the spherical texture mapping core and the bind that
// attaches them. Depends on stm_pkg and spherical_texture_mapping_core.
`timescale 1ns / 1ps

module stm_checker
  import stm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     normal_valid,
  input logic     normal_stall,
  input stm_in_t  normal,
  input logic     tex_valid,
  input logic     tex_stall,
  input stm_out_t tex
);

  // A held result beat keeps its value.
  a_tex_hold: assert property (@(posedge clk) disable iff (rst)
    tex_valid && tex_stall |=> tex_valid && $stable(tex))
    else $error("tex beat changed while stalled");

  // A held normal beat keeps its value.
  a_normal_hold: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal_stall |=> normal_valid && $stable(normal))
    else $error("normal beat changed while stalled");

  // The input is only held back by a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    normal_stall |-> tex_valid && tex_stall)
    else $error("normal stalled without a held result");

  // The polar coordinate never exceeds one.
  a_v_range: assert property (@(posedge clk) disable iff (rst)
    tex_valid |-> tex.tex_v <= 17'd65536)
    else $error("tex_v out of range");

  // Nothing appears at the output straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tex_valid)
    else $error("tex valid right after reset");

endmodule

bind spherical_texture_mapping_core stm_checker u_stm_checker (
  .clk         (clk),
  .rst         (rst),
  .normal_valid(normal_valid),
  .normal_stall(normal_stall),
  .normal      (normal),
  .tex_valid   (tex_valid),
  .tex_stall   (tex_stall),
  .tex         (tex)
);

FILE: sim/spherical_texture_mapping_core_test.sv
// Testbench for the spherical texture mapping core: directed and random normals,
// predicted texture coordinates checked beat by beat. Depends on stm_pkg and the core.
`timescale 1ns / 1ps

module spherical_texture_mapping_core_test;
  import stm_pkg::*;

  localparam int Iters = 16;
  localparam int Latency = Iters + 18;
  localparam longint CycleLimit = 400000;

  logic     clk;
  logic     rst;
  logic     normal_valid;
  logic     normal_stall;
  stm_in_t  normal;
  logic     tex_valid;
  logic     tex_stall;
  stm_out_t tex;

  stm_out_t tex_expected_q[$];
  int       fail_count;
  int       sent_count;
  int       got_count;
  longint   cycle_count;
  bit       sink_idle_enable;
  bit       src_idle_enable;

  spherical_texture_mapping_core #(.ANGLE_ITERATIONS(Iters)) u_dut (
    .clk(clk), .rst(rst),
    .normal_valid(normal_valid), .normal_stall(normal_stall), .normal(normal),
    .tex_valid(tex_valid), .tex_stall(tex_stall), .tex(tex)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint atan_entry(input int i);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756,
                        42667331, 21354465, 10679838, 5340245,
                        2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861,
                        10430, 5215, 2608, 1304,
                        652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  // Vectoring CORDIC in 2^-32 turns; >>> on longint floors negative values.
  function automatic longint cordic_angle(input longint x, input longint y);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 64'sd2147483648;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < Iters && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + atan_entry(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - atan_entry(i);
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(input longint n);
    longint r;
    r = 0;
    for (longint b = 64'sd1 <<< 30; b != 0; b = b >>> 2) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
    end
    return r;
  endfunction

  function automatic stm_out_t map_normal(input stm_in_t n);
    stm_out_t o;
    longint az;
    longint pol;
    longint z;
    longint s;
    z = longint'(n.normal_z);
    az = cordic_angle(longint'(n.normal_x), longint'(n.normal_y));
    o.tex_u = 16'((az + 32768) >>> 16);
    s = floor_sqrt((64'sd1 <<< 30) - z * z);
    pol = cordic_angle(z, s);
    if (pol < 0) pol = 0;
    if (pol > 64'sd2147483648) pol = 64'sd2147483648;
    o.tex_v = 17'((pol + 16384) >>> 15);
    return o;
  endfunction

  // Sends one beat, with an optional random gap before it.
  task automatic send_normal(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    stm_in_t n;
    int gap;
    n.normal_x = x;
    n.normal_y = y;
    n.normal_z = z;
    if (src_idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      normal_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    normal_valid <= 1'b1;
    normal <= n;
    @(posedge clk);
    while (normal_stall) @(posedge clk);
    tex_expected_q.push_back(map_normal(n));
    sent_count++;
  endtask

  task automatic finish_sending();
    normal_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
    send_normal(16'h0000, 16'h0000, 16'h0000);   // zero azimuth vector
    send_normal(16'h0000, 16'h0000, 16'h8000);   // z of exactly -1
    send_normal(16'h0000, 16'h0000, 16'h7fff);
    send_normal(16'hc000, 16'h0000, 16'h0000);   // negative x on the axis
    send_normal(16'hc000, 16'hc000, 16'h4000);
    send_normal(16'h4000, 16'hc000, 16'hc000);
    send_normal(16'h8000, 16'h0001, 16'h0001);
    send_normal(16'h8000, 16'hffff, 16'hffff);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 3; j++)
        send_normal(ext[i], ext[(i + j + 1) % 5], ext[(i + 2 * j) % 5]);
  endtask

  task automatic test_random(input int count);
    logic [15:0] r[3];
    for (int k = 0; k < count; k++) begin
      for (int f = 0; f < 3; f++) begin
        case ($urandom_range(0, 5))
          0: r[f] = 16'($urandom_range(0, 15) - 8);
          1: r[f] = 16'(32'h8000 + $urandom_range(0, 7));
          2: r[f] = 16'(32'h7fff - $urandom_range(0, 7));
          default: r[f] = 16'($urandom);
        endcase
      end
      send_normal(r[0], r[1], r[2]);
    end
  endtask

  task automatic wait_drained();
    while (tex_expected_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // Output side: random stall bursts, and the check of each beat.
  initial begin
    int burst;
    tex_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (sink_idle_enable && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        tex_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      tex_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    stm_out_t want;
    if (!rst && tex_valid && !tex_stall) begin
      got_count++;
      if (tex_expected_q.size() == 0) begin
        $error("tex beat with no expectation waiting: u=%0d v=%0d", tex.tex_u, tex.tex_v);
        fail_count++;
      end else begin
        want = tex_expected_q.pop_front();
        if (tex.tex_u !== want.tex_u) begin
          $error("tex_u expected %0d actual %0d", want.tex_u, tex.tex_u);
          fail_count++;
        end
        if (tex.tex_v !== want.tex_v) begin
          $error("tex_v expected %0d actual %0d", want.tex_v, tex.tex_v);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("spherical_texture_mapping_core_test: errors");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    sent_count = 0;
    got_count = 0;
    cycle_count = 0;
    sink_idle_enable = 1'b1;
    src_idle_enable = 1'b1;
    rst <= 1'b1;
    normal_valid <= 1'b0;
    normal <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(420);
    // The last stretch runs at full rate with no idling on either side.
    sink_idle_enable = 1'b0;
    src_idle_enable = 1'b0;
    test_random(80);
    finish_sending();
    wait_drained();
    if (tex_expected_q.size() != 0) fail_count++;
    $display("Sent %0d normals (directed extremes and random), checked %0d beats.",
             sent_count, got_count);
    if (fail_count == 0) begin
      $display("spherical_texture_mapping_core_test: clean");
    end else begin
      $display("spherical_texture_mapping_core_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/stm_pkg.sv
src/stm_sqrt_cell.sv
src/stm_cordic_cell.sv
src/spherical_texture_mapping_core.sv
src/stm_checker.sv
sim/spherical_texture_mapping_core_test.sv
